// File: design/swinging_door_segment_compressor_assert.svh
// assertion macros for the swinging door segment compressor
`ifndef SWINGING_DOOR_SEGMENT_COMPRESSOR_ASSERT_SVH
`define SWINGING_DOOR_SEGMENT_COMPRESSOR_ASSERT_SVH

// implication checked at every clock edge outside reset
`define SDSC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define SDSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sdsc_pkg.sv
// ---------------------------------------------------------------------------
// sdsc_pkg
// shared types and constants of the swinging door segment compressor
// ---------------------------------------------------------------------------
package sdsc_pkg;

    localparam int MAX_SEGMENT_LENGTH = 256;
    localparam int QDEPTH = 2;

    localparam logic [1:0] REG_ERR_TOL  = 2'd0;
    localparam logic [1:0] REG_SLOPE_LO = 2'd1;
    localparam logic [1:0] REG_SLOPE_HI = 2'd2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] sample;
    } t_item;

    typedef struct packed {
        logic signed [15:0] start;
        logic signed [31:0] slope;
        logic [7:0]         length;
    } t_result;

    typedef struct packed {
        logic [15:0]        err_tol;
        logic signed [31:0] slope_lo;
        logic signed [31:0] slope_hi;
    } t_cfg;

endpackage

// File: design/sdsc_front.sv
// ---------------------------------------------------------------------------
// sdsc_front
// accepts input words into a short queue towards the segment engine
// ---------------------------------------------------------------------------
module sdsc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sdsc_pkg::t_item      i_item,
    output logic                 o_q_valid,
    input  logic                 i_q_pop,
    output sdsc_pkg::t_item      o_q_item
);
    import sdsc_pkg::*;

    t_item      r_mem [QDEPTH];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push, pop;

    assign o_ready   = (r_cnt != 2'(QDEPTH));
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// File: design/sdsc_divider.sv
// ---------------------------------------------------------------------------
// sdsc_divider
// restoring divider, signed 34-bit numerator by unsigned 8-bit length
// ---------------------------------------------------------------------------
module sdsc_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [33:0]  i_num,
    input  logic [7:0]          i_den,
    output logic                o_done,
    output logic signed [34:0]  o_quot
);

    logic [33:0] r_q, n_q;
    logic [7:0]  r_rem, n_rem;
    logic [7:0]  r_den;
    logic        r_neg;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_fin;
    logic [8:0]  trial;
    logic [33:0] mag;

    assign mag   = i_num[33] ? 34'(-i_num) : i_num;
    assign trial = {r_rem, r_q[33]} - {1'b0, r_den};

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_q    = mag;
            n_rem  = 8'd0;
            n_cnt  = 6'd34;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!trial[8]) begin
                n_rem = trial[7:0];
                n_q   = {r_q[32:0], 1'b1};
            end else begin
                n_rem = {r_rem[6:0], r_q[33]};
                n_q   = {r_q[32:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
            r_fin  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            // quotient is ready in the same cycle as busy falls
            r_fin  <= r_busy && (r_cnt == 6'd1) && !i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
            r_neg <= i_num[33];
        end
    end

    assign o_done = r_fin;
    assign o_quot = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

endmodule

// File: design/sdsc_back.sv
// ---------------------------------------------------------------------------
// sdsc_back
// segment engine: bound narrowing over a shared serial divider
// ---------------------------------------------------------------------------
module sdsc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_pop,
    input  sdsc_pkg::t_item     i_q_item,
    input  sdsc_pkg::t_cfg      i_cfg,
    output logic                o_valid,
    input  logic                i_ready,
    output sdsc_pkg::t_result   o_res,
    output logic                o_idle
);
    import sdsc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RAW   = 5'b00010,
        S_UP    = 5'b00100,
        S_DOWN  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_st, n_st;
    logic signed [15:0] r_start;
    logic signed [31:0] r_floor, r_ceil;
    logic [7:0]         r_len;
    logic signed [15:0] r_smp;
    logic signed [34:0] r_upq;
    logic               r_ovld;
    t_result            r_out;
    logic               r_busy_d;

    logic               div_start, div_done;
    logic signed [33:0] div_num;
    logic signed [34:0] div_q;
    logic signed [16:0] diff;
    logic signed [17:0] derr;
    logic               limit_hit;
    logic signed [32:0] msum;
    logic               can_emit;
    logic               start_raw, do_close, do_open, extend;
    logic signed [31:0] new_floor, new_ceil;

    sdsc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_len),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign diff = 17'(r_smp) - 17'(r_start);
    assign limit_hit = (32'(r_len) + 32'd1 >= 32'(MAX_SEGMENT_LENGTH)) || (r_len == 8'd255);
    assign msum = 33'(r_floor) + 33'(r_ceil);
    assign o_valid = r_ovld;
    assign o_res   = r_out;
    assign o_idle  = (r_st == S_IDLE) && !r_ovld;

    always_comb begin
        derr = 18'(diff);
        unique case (r_st)
            S_UP:    derr = 18'(diff) - 18'($signed({1'b0, i_cfg.err_tol}));
            S_DOWN:  derr = 18'(diff) + 18'($signed({1'b0, i_cfg.err_tol}));
            default: derr = 18'(diff);
        endcase
        // numerator times 2^14, kept signed
        div_num = 34'($signed({derr, 14'd0}));
    end

    assign can_emit = !r_ovld || i_ready;
    assign o_q_pop  = (r_st == S_IDLE) && i_q_valid && can_emit;

    always_comb begin
        n_st = r_st;
        div_start = 1'b0;
        do_close = 1'b0;
        do_open = 1'b0;
        start_raw = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (o_q_pop) begin
                    if (i_q_item.kind == KIND_FLUSH) begin
                        do_close = (r_len != 8'd0);
                    end else if (r_len == 8'd0) begin
                        do_open = 1'b1;
                    end else if (limit_hit) begin
                        do_close = 1'b1;
                        do_open = 1'b1;
                    end else begin
                        start_raw = 1'b1;
                        n_st = S_RAW;
                    end
                end
            end
            S_RAW: begin
                div_start = !r_busy_d;
                if (div_done) begin
                    if (div_q < 35'(i_cfg.slope_lo) || div_q > 35'(i_cfg.slope_hi)) begin
                        n_st = S_EMIT;
                    end else begin
                        n_st = S_UP;
                    end
                end
            end
            S_UP: begin
                div_start = !r_busy_d;
                if (div_done) begin
                    n_st = S_DOWN;
                end
            end
            S_DOWN: begin
                div_start = !r_busy_d;
                if (div_done) begin
                    if (r_upq > 35'(r_ceil) || div_q < 35'(r_floor)) begin
                        n_st = S_EMIT;
                    end else begin
                        n_st = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (can_emit) begin
                    do_close = 1'b1;
                    do_open = 1'b1;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    // divider launch tracking: one launch per divide state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_d <= 1'b0;
        end else if (div_done) begin
            r_busy_d <= 1'b0;
        end else if (div_start) begin
            r_busy_d <= 1'b1;
        end
    end

    assign extend    = (r_st == S_DOWN) && div_done && (n_st == S_IDLE);
    assign new_floor = (r_upq > 35'(r_floor)) ? r_upq[31:0] : r_floor;
    assign new_ceil  = (div_q < 35'(r_ceil)) ? div_q[31:0] : r_ceil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_len  <= 8'd0;
            r_ovld <= 1'b0;
            r_start <= 16'sd0;
            r_floor <= 32'sh8000_0000;
            r_ceil  <= 32'sh7fff_ffff;
        end else begin
            r_st <= n_st;
            if (do_close) begin
                r_ovld <= 1'b1;
            end else if (r_ovld && i_ready) begin
                r_ovld <= 1'b0;
            end
            if (start_raw) begin
                r_smp <= i_q_item.sample;
            end
            if (r_st == S_UP && div_done) begin
                r_upq <= div_q;
            end
            if (do_close) begin
                r_out.start  <= r_start;
                r_out.slope  <= msum[32:1] + 32'(msum[32] & msum[0]);
                r_out.length <= r_len;
            end
            if (do_open) begin
                r_start <= (r_st == S_EMIT) ? r_smp : i_q_item.sample;
            end
            if (do_open) begin
                r_floor <= i_cfg.slope_lo;
                r_ceil  <= i_cfg.slope_hi;
            end else if (extend) begin
                r_floor <= new_floor;
                r_ceil  <= new_ceil;
            end
            if (do_open) begin
                r_len <= 8'd1;
            end else if (do_close) begin
                r_len <= 8'd0;
            end else if (extend) begin
                r_len <= r_len + 8'd1;
            end
        end
    end

endmodule

// File: design/swinging_door_segment_compressor.sv
// ---------------------------------------------------------------------------
// swinging_door_segment_compressor
// lossy piecewise-linear compressor of a sample stream
// ---------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       input      i_valid / o_ready    i_kind, i_sample
// out      output     o_valid / i_ready    o_segment_start/slope/length
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// a sample that extends a segment runs three divides (launch, restoring steps
// over the 34-bit magnitude, done) on the one shared serial divider; the band
// check closes the segment after the third, an out-of-range raw slope after
// the first; opening, the length limit and a flush need no divide; a result
// waiting on i_ready holds the next pop; a two-word queue keeps input flowing;
// synchronous active-low reset empties the queue and drops the segment
// ---------------------------------------------------------------------------
module swinging_door_segment_compressor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic         i_kind,
    input  logic [15:0]  i_sample,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [15:0]  o_segment_start,
    output logic [31:0]  o_segment_slope,
    output logic [7:0]   o_segment_length,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import sdsc_pkg::*;
    `include "swinging_door_segment_compressor_assert.svh"

    t_cfg    r_cfg;
    t_item   q_item, in_item;
    t_result res;
    logic    q_valid, q_pop, idle;

    assign in_item.kind   = i_kind;
    assign in_item.sample = i_sample;
    assign o_cfg_ready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.err_tol  <= 16'd0;
            r_cfg.slope_lo <= 32'sh8000_0000;
            r_cfg.slope_hi <= 32'sh7fff_ffff;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ERR_TOL:  r_cfg.err_tol  <= i_cfg_data[15:0];
                REG_SLOPE_LO: r_cfg.slope_lo <= i_cfg_data;
                REG_SLOPE_HI: r_cfg.slope_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sdsc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (in_item),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop),
        .o_q_item  (q_item)
    );

    sdsc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_item  (q_item),
        .i_cfg     (r_cfg),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_res     (res),
        .o_idle    (idle)
    );

    assign o_segment_start  = res.start;
    assign o_segment_slope  = res.slope;
    assign o_segment_length = res.length;

    `SDSC_ASSERT_IMP(a_len_nonzero, o_valid, o_segment_length != 8'd0, "zero length segment")
    `SDSC_ASSERT_NEXT(a_hold, o_valid && !i_ready, o_valid && $stable(o_segment_slope), "result dropped")
    `SDSC_ASSERT_IMP(a_pop_valid, q_pop, q_valid, "pop from empty queue")
    `SDSC_ASSERT_IMP(a_cfg_quiet, i_cfg_valid, idle && !q_valid, "config write while busy")

endmodule
